// ----- rtl/linear_diophantine_solver_defines.svh -----
// assertion macros for the linear diophantine solver
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef LINEAR_DIOPHANTINE_SOLVER_DEFINES_SVH
`define LINEAR_DIOPHANTINE_SOLVER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// consequent must hold in the same cycle as the antecedent
`define LDS_CHECK_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lds check failed");
// consequent must hold in the cycle after the antecedent
`define LDS_CHECK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lds check failed");
`else
`define LDS_CHECK_SAME(name, ante, cons)
`define LDS_CHECK_NEXT(name, ante, cons)
`endif
`endif

// ----- rtl/lds_pkg.sv -----
// shared types and constants of the linear diophantine solver
// no dependencies
package lds_pkg;

  localparam int DATA_BITS   = 32;
  localparam int COUNT_BITS  = 33;
  localparam int STATUS_BITS = 2;

  // result status codes
  typedef enum logic [STATUS_BITS-1:0] {
    ST_SOLVED    = 2'd0,
    ST_NO_DIV    = 2'd1,
    ST_NO_NONNEG = 2'd2,
    ST_INVALID   = 2'd3
  } status_code_t;

  // how an item finished
  typedef enum logic [2:0] {
    FIN_OK     = 3'd0,
    FIN_ZERO   = 3'd1,
    FIN_NDIV   = 3'd2,
    FIN_NONNEG = 3'd3,
    FIN_INV    = 3'd4
  } fin_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE   = 5'd0,
    OP_LOAD   = 5'd1,
    OP_GCD    = 5'd2,
    OP_SETG   = 5'd3,
    OP_CMOD   = 5'd4,
    OP_DIVA   = 5'd5,
    OP_DIVB   = 5'd6,
    OP_DIVC   = 5'd7,
    OP_SWAP   = 5'd8,
    OP_EDIV   = 5'd9,
    OP_MULS   = 5'd10,
    OP_UPDS   = 5'd11,
    OP_MULT   = 5'd12,
    OP_UPDT   = 5'd13,
    OP_BRANCH = 5'd14,
    OP_SMMAG  = 5'd15,
    OP_SMC    = 5'd16,
    OP_SMMUL  = 5'd17,
    OP_SMPMOD = 5'd18,
    OP_OKMUL  = 5'd19,
    OP_OKDIV  = 5'd20,
    OP_ASSIGN = 5'd21,
    OP_CNTX   = 5'd22,
    OP_CNTY   = 5'd23,
    OP_FIN    = 5'd24
  } op_t;

  typedef struct packed {
    op_t  op;
    fin_t fin;
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic gcd_run;
    logic c_zero;
    logic c_rem_nz;
    logic euc_run;
    logic fit_ok;
    logic div_done;
  } dp_stat_t;

endpackage

// ----- rtl/linear_diophantine_solver.sv -----
// top level of the linear diophantine solver
// depends on lds_pkg, lds_ctrl, lds_dpath and the defines header
`include "linear_diophantine_solver_defines.svh"

// Solves a*x + b*y = c for the non-negative solution with the least
// coefficient, and reports the gcd, the number of non-negative solutions and
// a status. One item is worked on at a time; a new beat is taken as soon as
// the previous result sits in the output register. Every division goes
// through one shared restoring divider at one bit per cycle. Invalid
// operands finish right after the operand check; zero or indivisible
// targets finish right after the gcd.
module linear_diophantine_solver #(
  parameter int OPERAND_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lds_pkg::DATA_BITS-1:0]   in_operand_a,
  input  logic [lds_pkg::DATA_BITS-1:0]   in_operand_b,
  input  logic [lds_pkg::DATA_BITS-1:0]   in_target_sum,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lds_pkg::STATUS_BITS-1:0] out_status,
  output logic [lds_pkg::DATA_BITS-1:0]   out_coef_x,
  output logic [lds_pkg::DATA_BITS-1:0]   out_coef_y,
  output logic [lds_pkg::DATA_BITS-1:0]   out_divisor,
  output logic [lds_pkg::COUNT_BITS-1:0]  out_solution_count
);
  import lds_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  // sequencer
  lds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // arithmetic and result register
  lds_dpath #(.W(OPERAND_BITS)) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_operand_a       (in_operand_a),
    .in_operand_b       (in_operand_b),
    .in_target_sum      (in_target_sum),
    .out_status         (out_status),
    .out_coef_x         (out_coef_x),
    .out_coef_y         (out_coef_y),
    .out_divisor        (out_divisor),
    .out_solution_count (out_solution_count)
  );

  // checks
  `LDS_CHECK_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `LDS_CHECK_SAME(a_invalid_clears, out_valid && out_status == ST_INVALID,
                  out_divisor == '0 && out_solution_count == '0)
  `LDS_CHECK_SAME(a_solved_counts, out_valid && out_status == ST_SOLVED,
                  out_solution_count != '0)

endmodule

// ----- rtl/lds_div.sv -----
// restoring divider, one quotient bit per cycle, narrow or double-width dividend
// depends on nothing
module lds_div #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           wide,
  input  logic [2*W-1:0] dividend,
  input  logic [W-1:0]   divisor,
  output logic           done,
  output logic [W-1:0]   quotient,
  output logic [W-1:0]   remainder
);

  localparam int PW   = 2 * W;
  localparam int CNTW = $clog2(PW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [PW-1:0]   sh_r;
  logic [W-1:0]    rem_r;
  logic [W-1:0]    dvs_r;
  logic [W:0]      trial;
  logic [W:0]      diff;
  logic            fits;

  // one restoring step
  assign trial = {rem_r, sh_r[PW-1]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign diff  = fits ? (trial - {1'b0, dvs_r}) : trial;

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= wide ? CNTW'(PW) : CNTW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift register and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      sh_r  <= wide ? dividend : {dividend[W-1:0], {W{1'b0}}};
    end else if (busy_r) begin
      rem_r <= diff[W-1:0];
      sh_r  <= {sh_r[PW-2:0], fits};
    end
  end

  assign done      = done_r;
  assign quotient  = sh_r[W-1:0];
  assign remainder = rem_r;

endmodule

// ----- rtl/lds_dpath.sv -----
// datapath: operand registers, Bezout coefficients, multiplier, divider, result register
// depends on lds_pkg and lds_div
module lds_dpath #(
  parameter int W = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lds_pkg::cmd_t                  cmd,
  output lds_pkg::dp_stat_t              stat,
  input  logic [lds_pkg::DATA_BITS-1:0]  in_operand_a,
  input  logic [lds_pkg::DATA_BITS-1:0]  in_operand_b,
  input  logic [lds_pkg::DATA_BITS-1:0]  in_target_sum,
  output logic [lds_pkg::STATUS_BITS-1:0] out_status,
  output logic [lds_pkg::DATA_BITS-1:0]  out_coef_x,
  output logic [lds_pkg::DATA_BITS-1:0]  out_coef_y,
  output logic [lds_pkg::DATA_BITS-1:0]  out_divisor,
  output logic [lds_pkg::COUNT_BITS-1:0] out_solution_count
);
  import lds_pkg::*;

  localparam int SW = W + 2;
  localparam int PW = 2 * W;
  localparam int CW = W + 1;

  logic [W-1:0] a_r, b_r, c_r, g_r, ra_r, rb_r, rc_r, p_r, q_r;
  logic [W-1:0] r0_r, r1_r, qt_r, rn_r, m_r, vmag_r, tmp1_r, tmp2_r;
  logic [W-1:0] xm_r, xo_r, cx_r, cy_r;
  logic signed [SW-1:0] s0_r, s1_r, t0_r, t1_r;
  logic [PW-1:0] prod_r;
  logic [CW-1:0] cnt_r;
  logic swap_r, neg_r, vneg_r, gsel_r, cnz_r;
  op_t dop_r;

  status_code_t           ost_r;
  logic [DATA_BITS-1:0]   ox_r, oy_r, og_r;
  logic [COUNT_BITS-1:0]  ocnt_r;

  logic signed [SW-1:0] s1_abs, t1_abs, vsel, vsel_abs, prod_s;
  logic [W-1:0]  mul_a, mul_b;
  logic [PW-1:0] mul_p;
  logic          div_start, div_wide, div_done;
  logic [PW-1:0] div_dvd;
  logic [W-1:0]  div_dvs, div_quo, div_rem;
  logic          r0_ge;
  logic [W-1:0]  xq_v, xp_v;

  // magnitudes and signed product
  assign s1_abs   = s1_r[SW-1] ? -s1_r : s1_r;
  assign t1_abs   = t1_r[SW-1] ? -t1_r : t1_r;
  assign vsel     = t0_r[SW-1] ? t0_r : s0_r;
  assign vsel_abs = vsel[SW-1] ? -vsel : vsel;
  assign prod_s   = signed'(prod_r[SW-1:0]);
  assign r0_ge    = r0_r >= r1_r;

  // final coefficients before the swap is undone
  assign xq_v = neg_r ? xm_r : xo_r;
  assign xp_v = neg_r ? xo_r : xm_r;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MULS: begin
        mul_a = qt_r;
        mul_b = s1_abs[W-1:0];
      end
      OP_MULT: begin
        mul_a = qt_r;
        mul_b = t1_abs[W-1:0];
      end
      OP_SMMUL: begin
        mul_a = tmp1_r;
        mul_b = tmp2_r;
      end
      OP_OKMUL: begin
        mul_a = neg_r ? q_r : p_r;
        mul_b = xm_r;
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // divider operand select
  always_comb begin
    div_start = 1'b1;
    div_wide  = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (cmd.op)
      OP_GCD: begin
        div_dvd = PW'(r0_ge ? r0_r : r1_r);
        div_dvs = r0_ge ? r1_r : r0_r;
      end
      OP_CMOD, OP_DIVC: begin
        div_dvd = PW'(c_r);
        div_dvs = g_r;
      end
      OP_DIVA: begin
        div_dvd = PW'(a_r);
        div_dvs = g_r;
      end
      OP_DIVB: begin
        div_dvd = PW'(b_r);
        div_dvs = g_r;
      end
      OP_EDIV: begin
        div_dvd = PW'(r0_r);
        div_dvs = r1_r;
      end
      OP_SMMAG: begin
        div_dvd = PW'(vmag_r);
        div_dvs = m_r;
      end
      OP_SMC: begin
        div_dvd = PW'(rc_r);
        div_dvs = m_r;
      end
      OP_SMPMOD: begin
        div_wide = 1'b1;
        div_dvd  = prod_r;
        div_dvs  = m_r;
      end
      OP_OKDIV: begin
        div_dvd = PW'(rc_r - prod_r[W-1:0]);
        div_dvs = neg_r ? p_r : q_r;
      end
      OP_CNTX: begin
        div_dvd = PW'(cx_r);
        div_dvs = rb_r;
      end
      OP_CNTY: begin
        div_dvd = PW'(cy_r);
        div_dvs = ra_r;
      end
      default: div_start = 1'b0;
    endcase
  end

  lds_div #(.W(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .wide      (div_wide),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // register updates per command and per divider completion
  always_ff @(posedge clk) begin
    if (div_start) begin
      dop_r <= cmd.op;
    end
    case (cmd.op)
      OP_LOAD: begin
        a_r  <= in_operand_a[W-1:0];
        b_r  <= in_operand_b[W-1:0];
        c_r  <= in_target_sum[W-1:0];
        r0_r <= in_operand_a[W-1:0];
        r1_r <= in_operand_b[W-1:0];
      end
      OP_GCD:  gsel_r <= r0_ge;
      OP_SETG: g_r <= r0_r | r1_r;
      OP_SWAP: begin
        swap_r <= ra_r < rb_r;
        p_r    <= (ra_r < rb_r) ? rb_r : ra_r;
        q_r    <= (ra_r < rb_r) ? ra_r : rb_r;
        r0_r   <= (ra_r < rb_r) ? rb_r : ra_r;
        r1_r   <= (ra_r < rb_r) ? ra_r : rb_r;
        s0_r   <= SW'(1);
        s1_r   <= '0;
        t0_r   <= '0;
        t1_r   <= SW'(1);
      end
      OP_MULS, OP_MULT, OP_SMMUL, OP_OKMUL: prod_r <= mul_p;
      OP_UPDS: begin
        s0_r <= s1_r;
        s1_r <= s0_r - (s1_r[SW-1] ? -prod_s : prod_s);
      end
      OP_UPDT: begin
        t0_r <= t1_r;
        t1_r <= t0_r - (t1_r[SW-1] ? -prod_s : prod_s);
        r0_r <= r1_r;
        r1_r <= rn_r;
      end
      OP_BRANCH: begin
        neg_r  <= t0_r[SW-1];
        vneg_r <= vsel[SW-1];
        vmag_r <= vsel_abs[W-1:0];
        m_r    <= t0_r[SW-1] ? p_r : q_r;
      end
      OP_ASSIGN: begin
        cx_r <= swap_r ? xq_v : xp_v;
        cy_r <= swap_r ? xp_v : xq_v;
      end
      OP_FIN: begin
        case (cmd.fin)
          FIN_OK: begin
            ost_r  <= ST_SOLVED;
            ox_r   <= DATA_BITS'(cx_r);
            oy_r   <= DATA_BITS'(cy_r);
            og_r   <= DATA_BITS'(g_r);
            ocnt_r <= COUNT_BITS'(cnt_r);
          end
          FIN_ZERO: begin
            ost_r  <= ST_SOLVED;
            ox_r   <= '0;
            oy_r   <= '0;
            og_r   <= DATA_BITS'(g_r);
            ocnt_r <= COUNT_BITS'(1);
          end
          FIN_NDIV: begin
            ost_r  <= ST_NO_DIV;
            ox_r   <= '0;
            oy_r   <= '0;
            og_r   <= DATA_BITS'(g_r);
            ocnt_r <= '0;
          end
          FIN_NONNEG: begin
            ost_r  <= ST_NO_NONNEG;
            ox_r   <= '0;
            oy_r   <= '0;
            og_r   <= DATA_BITS'(g_r);
            ocnt_r <= '0;
          end
          default: begin
            ost_r  <= ST_INVALID;
            ox_r   <= '0;
            oy_r   <= '0;
            og_r   <= '0;
            ocnt_r <= '0;
          end
        endcase
      end
      default: ;
    endcase

    // write back a finished division
    if (div_done) begin
      case (dop_r)
        OP_GCD: begin
          if (gsel_r) begin
            r0_r <= div_rem;
          end else begin
            r1_r <= div_rem;
          end
        end
        OP_CMOD: cnz_r <= div_rem != '0;
        OP_DIVA: ra_r <= div_quo;
        OP_DIVB: rb_r <= div_quo;
        OP_DIVC: rc_r <= div_quo;
        OP_EDIV: begin
          qt_r <= div_quo;
          rn_r <= div_rem;
        end
        OP_SMMAG: tmp1_r <= div_rem;
        OP_SMC:   tmp2_r <= div_rem;
        OP_SMPMOD: xm_r <= (vneg_r && div_rem != '0) ? (m_r - div_rem) : div_rem;
        OP_OKDIV: xo_r <= div_quo;
        OP_CNTX:  cnt_r <= CW'(div_quo) + CW'(1);
        OP_CNTY:  cnt_r <= cnt_r + CW'(div_quo);
        default: ;
      endcase
    end
  end

  // status toward the controller
  assign stat.invalid  = (a_r == '0) || (b_r == '0) || (a_r == b_r);
  assign stat.gcd_run  = (r0_r != '0) && (r1_r != '0);
  assign stat.c_zero   = c_r == '0;
  assign stat.c_rem_nz = cnz_r;
  assign stat.euc_run  = r1_r != '0;
  assign stat.fit_ok   = PW'(rc_r) >= prod_r;
  assign stat.div_done = div_done;

  assign out_status         = ost_r;
  assign out_coef_x         = ox_r;
  assign out_coef_y         = oy_r;
  assign out_divisor        = og_r;
  assign out_solution_count = ocnt_r;

endmodule

// ----- rtl/lds_ctrl.sv -----
// controller: sequences gcd, reduction, extended Euclid, shift and count steps
// depends on lds_pkg
module lds_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output lds_pkg::cmd_t     cmd,
  input  lds_pkg::dp_stat_t stat
);
  import lds_pkg::*;

  typedef enum logic [23:0] {
    S_IDLE   = 24'h000001,
    S_CHECK  = 24'h000002,
    S_GCD    = 24'h000004,
    S_CZERO  = 24'h000008,
    S_CREM   = 24'h000010,
    S_DIVB   = 24'h000020,
    S_DIVC   = 24'h000040,
    S_SWAP   = 24'h000080,
    S_EUC    = 24'h000100,
    S_MULS   = 24'h000200,
    S_UPDS   = 24'h000400,
    S_MULT   = 24'h000800,
    S_UPDT   = 24'h001000,
    S_SMMAG  = 24'h002000,
    S_SMC    = 24'h004000,
    S_SMMUL  = 24'h008000,
    S_SMPMOD = 24'h010000,
    S_OKMUL  = 24'h020000,
    S_OKCHK  = 24'h040000,
    S_ASSIGN = 24'h080000,
    S_CNTX   = 24'h100000,
    S_CNTY   = 24'h200000,
    S_FIN    = 24'h400000,
    S_WAIT   = 24'h800000
  } state_t;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;
  fin_t   fin_r, fin_nxt;
  logic   out_valid_r, out_valid_nxt;
  op_t    op;

  // next state and command
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    fin_nxt   = fin_r;
    op        = OP_NONE;
    case (state_r)
      S_IDLE: if (in_valid) begin
        op        = OP_LOAD;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.invalid) begin
          fin_nxt   = FIN_INV;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (stat.gcd_run) begin
          op        = OP_GCD;
          ret_nxt   = S_GCD;
          state_nxt = S_WAIT;
        end else begin
          op        = OP_SETG;
          state_nxt = S_CZERO;
        end
      end
      S_CZERO: begin
        if (stat.c_zero) begin
          fin_nxt   = FIN_ZERO;
          state_nxt = S_FIN;
        end else begin
          op        = OP_CMOD;
          ret_nxt   = S_CREM;
          state_nxt = S_WAIT;
        end
      end
      S_CREM: begin
        if (stat.c_rem_nz) begin
          fin_nxt   = FIN_NDIV;
          state_nxt = S_FIN;
        end else begin
          op        = OP_DIVA;
          ret_nxt   = S_DIVB;
          state_nxt = S_WAIT;
        end
      end
      S_DIVB: begin
        op        = OP_DIVB;
        ret_nxt   = S_DIVC;
        state_nxt = S_WAIT;
      end
      S_DIVC: begin
        op        = OP_DIVC;
        ret_nxt   = S_SWAP;
        state_nxt = S_WAIT;
      end
      S_SWAP: begin
        op        = OP_SWAP;
        state_nxt = S_EUC;
      end
      // one Euclid step: divide, then update s and t
      S_EUC: begin
        if (stat.euc_run) begin
          op        = OP_EDIV;
          ret_nxt   = S_MULS;
          state_nxt = S_WAIT;
        end else begin
          op        = OP_BRANCH;
          state_nxt = S_SMMAG;
        end
      end
      S_MULS: begin
        op        = OP_MULS;
        state_nxt = S_UPDS;
      end
      S_UPDS: begin
        op        = OP_UPDS;
        state_nxt = S_MULT;
      end
      S_MULT: begin
        op        = OP_MULT;
        state_nxt = S_UPDT;
      end
      S_UPDT: begin
        op        = OP_UPDT;
        state_nxt = S_EUC;
      end
      // least residue of the scaled coefficient
      S_SMMAG: begin
        op        = OP_SMMAG;
        ret_nxt   = S_SMC;
        state_nxt = S_WAIT;
      end
      S_SMC: begin
        op        = OP_SMC;
        ret_nxt   = S_SMMUL;
        state_nxt = S_WAIT;
      end
      S_SMMUL: begin
        op        = OP_SMMUL;
        state_nxt = S_SMPMOD;
      end
      S_SMPMOD: begin
        op        = OP_SMPMOD;
        ret_nxt   = S_OKMUL;
        state_nxt = S_WAIT;
      end
      S_OKMUL: begin
        op        = OP_OKMUL;
        state_nxt = S_OKCHK;
      end
      S_OKCHK: begin
        if (!stat.fit_ok) begin
          fin_nxt   = FIN_NONNEG;
          state_nxt = S_FIN;
        end else begin
          op        = OP_OKDIV;
          ret_nxt   = S_ASSIGN;
          state_nxt = S_WAIT;
        end
      end
      S_ASSIGN: begin
        op        = OP_ASSIGN;
        state_nxt = S_CNTX;
      end
      S_CNTX: begin
        op        = OP_CNTX;
        ret_nxt   = S_CNTY;
        state_nxt = S_WAIT;
      end
      S_CNTY: begin
        op        = OP_CNTY;
        fin_nxt   = FIN_OK;
        ret_nxt   = S_FIN;
        state_nxt = S_WAIT;
      end
      S_WAIT: if (stat.div_done) begin
        state_nxt = ret_r;
      end
      // hand the result to the output register once it is free
      S_FIN: if (!out_valid_r || !out_stall) begin
        op        = OP_FIN;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output beat tracking
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (op == OP_FIN) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      fin_r       <= FIN_INV;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign cmd.op    = op;
  assign cmd.fin   = fin_r;

endmodule

// ----- tb/linear_diophantine_solver_tb.sv -----
// testbench for the linear diophantine solver: directed and random beats
// depends on lds_pkg and the linear_diophantine_solver top level
`timescale 1ns / 100ps

module linear_diophantine_solver_tb;
  import lds_pkg::*;

  localparam int WATCHDOG_CYCLES = 200000;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] coef_x;
    logic [31:0] coef_y;
    logic [31:0] divisor;
    logic [32:0] count;
  } solution_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_operand_a = '0;
  logic [31:0] in_operand_b = '0;
  logic [31:0] in_target_sum = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_coef_x;
  logic [31:0] out_coef_y;
  logic [31:0] out_divisor;
  logic [32:0] out_solution_count;

  solution_t expected_solutions[$];
  int        error_count = 0;
  int        beats_sent = 0;
  int        beats_checked = 0;
  int        idle_cycles = 0;
  bit        gaps_on = 1'b1;

  linear_diophantine_solver uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .in_target_sum(in_target_sum),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_coef_x(out_coef_x), .out_coef_y(out_coef_y),
    .out_divisor(out_divisor), .out_solution_count(out_solution_count)
  );

  always #4 clk = ~clk;

  // gcd by repeated remainder
  function automatic longint unsigned gcd_calc(longint unsigned p, longint unsigned q);
    while (p != 0 && q != 0) begin
      if (p >= q) p = p % q;
      else q = q % p;
    end
    return p | q;
  endfunction

  // least residue of v*c mod m, v signed
  function automatic longint unsigned residue_of(longint v, longint unsigned c,
                                                 longint unsigned m);
    longint unsigned mag;
    longint unsigned r;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    r = ((mag % m) * (c % m)) % m;
    if (v < 0 && r != 0) r = m - r;
    return r;
  endfunction

  // predicted result of one beat
  function automatic solution_t solve_equation(logic [31:0] a, logic [31:0] b,
                                               logic [31:0] c);
    solution_t res;
    longint unsigned g, ra, rb, rc, p, q, xp, xq, r0, r1, rn, qt;
    longint s0, s1, t0, t1, sn, tn;
    bit swapped, fits;
    res = '{ST_SOLVED, 32'd0, 32'd0, 32'd0, 33'd0};
    if (a == 0 || b == 0 || a == b) begin
      res.status = ST_INVALID;
      return res;
    end
    g = gcd_calc(a, b);
    res.divisor = g[31:0];
    if (c == 0) begin
      res.count = 33'd1;
      return res;
    end
    if (c % g != 0) begin
      res.status = ST_NO_DIV;
      return res;
    end
    ra = a / g; rb = b / g; rc = c / g;
    swapped = ra < rb;
    p = swapped ? rb : ra;
    q = swapped ? ra : rb;
    // extended euclid on p >= q
    r0 = p; r1 = q; s0 = 1; s1 = 0; t0 = 0; t1 = 1;
    while (r1 != 0) begin
      qt = r0 / r1;
      rn = r0 - qt * r1;
      sn = s0 - longint'(qt) * s1;
      tn = t0 - longint'(qt) * t1;
      r0 = r1; r1 = rn; s0 = s1; s1 = sn; t0 = t1; t1 = tn;
    end
    if (t0 < 0) begin
      xq = residue_of(t0, rc, p);
      fits = rc >= q * xq;
      xp = fits ? (rc - q * xq) / p : 0;
    end else begin
      xp = residue_of(s0, rc, q);
      fits = rc >= p * xp;
      xq = fits ? (rc - p * xp) / q : 0;
    end
    if (!fits) begin
      res.status = ST_NO_NONNEG;
      return res;
    end
    res.coef_x = swapped ? xq[31:0] : xp[31:0];
    res.coef_y = swapped ? xp[31:0] : xq[31:0];
    res.count = 33'(longint'(res.coef_x) / rb + longint'(res.coef_y) / ra + 1);
    return res;
  endfunction

  // send one beat, with an optional random gap first
  task automatic send_equation(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    int gap;
    gap = gaps_on && ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operand_a <= a;
    in_operand_b <= b;
    in_target_sum <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_solutions.push_back(solve_equation(a, b, c));
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    release_input();
    while (expected_solutions.size() != 0) @(negedge clk);
  endtask

  // receiver stall pattern: periods of random stall and of none
  always @(negedge clk) begin
    if (beats_sent % 40 < 10) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 2) == 0);
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    solution_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_solutions.size() == 0) begin
        $error("result beat with nothing expected");
        error_count++;
      end else begin
        want = expected_solutions.pop_front();
        beats_checked++;
        if (out_status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_status);
          error_count++;
        end
        if (out_coef_x !== want.coef_x) begin
          $error("coef_x expected %0d actual %0d", want.coef_x, out_coef_x);
          error_count++;
        end
        if (out_coef_y !== want.coef_y) begin
          $error("coef_y expected %0d actual %0d", want.coef_y, out_coef_y);
          error_count++;
        end
        if (out_divisor !== want.divisor) begin
          $error("divisor expected %0d actual %0d", want.divisor, out_divisor);
          error_count++;
        end
        if (out_solution_count !== want.count) begin
          $error("solution_count expected %0d actual %0d", want.count,
                 out_solution_count);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // invalid operands, zero target and the field extremes
  task automatic test_special_cases();
    send_equation(32'd0, 32'd5, 32'd7);
    send_equation(32'd5, 32'd0, 32'd7);
    send_equation(32'd9, 32'd9, 32'd18);
    send_equation(32'd0, 32'd0, 32'd0);
    send_equation(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_equation(32'd6, 32'd10, 32'd0);
    send_equation(32'hFFFFFFFF, 32'hFFFFFFFE, 32'd0);
    send_equation(32'd6, 32'd10, 32'd7);
    send_equation(32'd4, 32'd6, 32'hFFFFFFFF);
    send_equation(32'd3, 32'd5, 32'd7);
    send_equation(32'd5, 32'd3, 32'd1);
    send_equation(32'd3, 32'd5, 32'd8);
    send_equation(32'd1, 32'd2, 32'hFFFFFFFF);
    send_equation(32'd2, 32'd1, 32'hFFFFFFFF);
    send_equation(32'd1, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_equation(32'hFFFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFF);
    send_equation(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
    send_equation(32'hB504F333, 32'h6A09E667, 32'hFFFFFFFE);
    send_equation(32'd12, 32'd18, 32'd600);
    send_equation(32'd1, 32'd3, 32'd0);
  endtask

  // the sender holds off until every result is back
  task automatic test_drain_pause();
    wait_drained();
    send_equation(32'd7, 32'd11, 32'd100);
    send_equation(32'd11, 32'd7, 32'd100);
    wait_drained();
  endtask

  // random equations, mostly solvable, with varied operand sizes
  task automatic test_random_equations(int n);
    logic [31:0] a, b, c, g;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: begin a = $urandom; b = $urandom; c = $urandom; end
        1: begin
          a = $urandom_range(1, 1000); b = $urandom_range(1, 1000);
          c = $urandom_range(0, 100000);
        end
        2: begin
          // shared factor, target a multiple of it
          g = $urandom_range(1, 300);
          a = g * $urandom_range(1, 5000); b = g * $urandom_range(1, 5000);
          c = g * $urandom_range(0, 1000000);
        end
        3: begin
          a = $urandom_range(1, 50); b = $urandom;
          c = $urandom;
        end
        4: begin
          a = $urandom; b = a + $urandom_range(0, 3) - 1;
          c = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom;
        end
        default: begin
          a = $urandom_range(1, 65535); b = $urandom_range(1, 65535);
          c = $urandom;
        end
      endcase
      gaps_on = (i % 60) >= 15;
      send_equation(a, b, c);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_special_cases();
    test_drain_pause();
    test_random_equations(300);
    wait_drained();
    repeat (500) @(negedge clk);
    $display("covered %0d beats sent and %0d results checked", beats_sent,
             beats_checked);
    $display("special cases, drain pause and random equations under stalls");
    if (error_count == 0 && expected_solutions.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- linear_diophantine_solver.f -----
+incdir+rtl
rtl/lds_pkg.sv
rtl/lds_div.sv
rtl/lds_dpath.sv
rtl/lds_ctrl.sv
rtl/linear_diophantine_solver.sv
tb/linear_diophantine_solver_tb.sv
